>>> hw/rtl/stream_substring_replace_macros.svh
// Assertion macros for the substring replacement block.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef STREAM_SUBSTRING_REPLACE_MACROS_SVH
`define STREAM_SUBSTRING_REPLACE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SSR_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SSR_ASSERT(lbl, prop, msg)
`define SSR_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

>>> hw/rtl/ssr_pkg.sv
// Shared types and constants of the substring replacement block.
// No dependencies.
`timescale 1ns / 1ps

package ssr_pkg;

  localparam int MAX_PATTERN_DEF     = 16;
  localparam int MAX_REPLACEMENT_DEF = 16;
  localparam int COUNT_WIDTH_DEF     = 16;

  localparam int BODY_BYTES  = 16;
  localparam int LEN_W       = $clog2(BODY_BYTES + 1);
  localparam int POS_W       = $clog2(BODY_BYTES);
  localparam int CNT_OUT_W   = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_LEN_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_HI  = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_byte_valid;
    logic       end_of_string;
  } ssr_in_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 out_byte_valid;
    logic                 out_last;
    logic [CNT_OUT_W-1:0] replace_count;
  } ssr_out_t;

  // one queued request: a run of bytes to emit, empty only for a bare end marker
  typedef struct packed {
    logic [BODY_BYTES-1:0][7:0] body;
    logic [LEN_W-1:0]           len;
    logic                       last;
    logic [CNT_OUT_W-1:0]       count;
  } ssr_cmd_t;

endpackage

>>> hw/rtl/ssr_fifo.sv
// Short request queue between the front and back parts.
// Depends on ssr_pkg and stream_substring_replace_macros.svh.
`timescale 1ns / 1ps
`include "stream_substring_replace_macros.svh"

module ssr_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ssr_pkg::ssr_cmd_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             avail_o,
  output ssr_pkg::ssr_cmd_t data_o
);

  ssr_pkg::ssr_cmd_t mem_q [ssr_pkg::QUEUE_DEPTH];
  logic [ssr_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [ssr_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == ssr_pkg::QCNT_W'(ssr_pkg::QUEUE_DEPTH));
  assign avail_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + ssr_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - ssr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + ssr_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + ssr_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `SSR_ASSERT_NEVER(a_push_full, push_i && full_o, "request pushed into full queue")
  `SSR_ASSERT_NEVER(a_pop_empty, pop_i && !avail_o, "request popped from empty queue")
  `SSR_ASSERT(a_cnt_bound, cnt_q <= ssr_pkg::QCNT_W'(ssr_pkg::QUEUE_DEPTH), "queue count overrun")

endmodule

>>> hw/rtl/ssr_front.sv
// Front part: configuration registers, match window and request builder.
// Depends on ssr_pkg and stream_substring_replace_macros.svh.
`timescale 1ns / 1ps
`include "stream_substring_replace_macros.svh"

module ssr_front #(
  parameter int MAX_PATTERN     = ssr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = ssr_pkg::MAX_REPLACEMENT_DEF,
  parameter int COUNT_WIDTH     = ssr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ssr_pkg::ssr_in_t                in_data_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            push_o,
  output ssr_pkg::ssr_cmd_t               cmd_o,
  input  logic                            full_i
);

  localparam int WinDepth  = (MAX_PATTERN < ssr_pkg::BODY_BYTES) ?
                             MAX_PATTERN : ssr_pkg::BODY_BYTES;
  localparam int ReplDepth = (MAX_REPLACEMENT < ssr_pkg::BODY_BYTES) ?
                             MAX_REPLACEMENT : ssr_pkg::BODY_BYTES;
  localparam int FillW     = $clog2(WinDepth + 1);

  logic [ssr_pkg::CFG_LEN_W-1:0] pat_len_q, repl_len_q;
  logic [WinDepth-1:0][7:0]      pat_q;
  logic [ReplDepth-1:0][7:0]     repl_q;
  logic [WinDepth-1:0][7:0]      win_q, win_d, win_n;
  logic [FillW-1:0]              fill_q, fill_d, fill_n, plen;
  logic [COUNT_WIDTH-1:0]        count_q, count_n;
  logic [COUNT_WIDTH+ssr_pkg::CNT_OUT_W-1:0] count_ext;
  logic [ssr_pkg::LEN_W-1:0]     rlen;
  logic [ssr_pkg::BODY_BYTES-1:0][7:0] win_pad, repl_pad;
  logic accept, v, eos, full, same, hit;
  logic cfg_we;

  assign accept      = in_valid_i && !full_i;
  assign in_stall_o  = full_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign v           = in_data_i.in_byte_valid;
  assign eos         = in_data_i.end_of_string;

  always_comb begin
    if (pat_len_q > ssr_pkg::CFG_LEN_W'(WinDepth)) begin
      plen = FillW'(WinDepth);
    end else begin
      plen = FillW'(pat_len_q);
    end
    if (repl_len_q > ssr_pkg::CFG_LEN_W'(ReplDepth)) begin
      rlen = ssr_pkg::LEN_W'(ReplDepth);
    end else begin
      rlen = ssr_pkg::LEN_W'(repl_len_q);
    end
  end

  // window with the new byte appended, then the full-window compare
  always_comb begin
    fill_n = fill_q + FillW'(v);
    same   = 1'b1;
    for (int i = 0; i < WinDepth; i++) begin
      win_n[i] = (v && (fill_q == FillW'(i))) ? in_data_i.in_byte : win_q[i];
    end
    for (int i = 0; i < WinDepth; i++) begin
      if ((FillW'(i) < plen) && (win_n[i] != pat_q[i])) begin
        same = 1'b0;
      end
    end
    full = v && (fill_n >= plen);
    hit  = full && (plen != '0) && same;
  end

  always_comb begin
    count_n = count_q;
    if (hit && (count_q != {COUNT_WIDTH{1'b1}})) begin
      count_n = count_q + COUNT_WIDTH'(1);
    end
    count_ext = {{ssr_pkg::CNT_OUT_W{1'b0}}, count_n};
  end

  always_comb begin
    win_pad  = '0;
    repl_pad = '0;
    for (int i = 0; i < WinDepth; i++) begin
      win_pad[i] = win_n[i];
    end
    for (int i = 0; i < ReplDepth; i++) begin
      repl_pad[i] = repl_q[i];
    end
    cmd_o.last  = eos;
    cmd_o.count = count_ext[ssr_pkg::CNT_OUT_W-1:0];
    if (hit) begin
      cmd_o.body = repl_pad;
      cmd_o.len  = rlen;
    end else begin
      cmd_o.body = win_pad;
      if (eos) begin
        cmd_o.len = ssr_pkg::LEN_W'(fill_n);
      end else if (full) begin
        cmd_o.len = ssr_pkg::LEN_W'(1);
      end else begin
        cmd_o.len = '0;
      end
    end
    push_o = accept && (eos || (cmd_o.len != '0));
  end

  // next window: emptied on a hit or at end, oldest byte dropped on a full-window miss
  always_comb begin
    win_d  = win_n;
    fill_d = fill_n;
    if (eos || hit) begin
      fill_d = '0;
    end else if (full) begin
      fill_d = fill_n - FillW'(1);
      for (int i = 0; i < WinDepth - 1; i++) begin
        win_d[i] = win_n[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      count_q <= '0;
    end else if (accept) begin
      fill_q  <= fill_d;
      count_q <= eos ? '0 : count_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q  <= '0;
      repl_len_q <= '0;
      pat_q      <= '0;
      repl_q     <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        ssr_pkg::CFG_PAT_LEN: begin
          if (fill_q == '0) begin
            pat_len_q <= cfg_data_i[ssr_pkg::CFG_LEN_W-1:0];
          end
        end
        ssr_pkg::CFG_PAT_LO: begin
          for (int k = 0; k < WinDepth; k++) begin
            if (k < 8) pat_q[k] <= cfg_data_i[8*(k%8) +: 8];
          end
        end
        ssr_pkg::CFG_PAT_HI: begin
          for (int k = 0; k < WinDepth; k++) begin
            if (k >= 8) pat_q[k] <= cfg_data_i[8*(k%8) +: 8];
          end
        end
        ssr_pkg::CFG_REPL_LEN: begin
          repl_len_q <= cfg_data_i[ssr_pkg::CFG_LEN_W-1:0];
        end
        ssr_pkg::CFG_REPL_LO: begin
          for (int k = 0; k < ReplDepth; k++) begin
            if (k < 8) repl_q[k] <= cfg_data_i[8*(k%8) +: 8];
          end
        end
        ssr_pkg::CFG_REPL_HI: begin
          for (int k = 0; k < ReplDepth; k++) begin
            if (k >= 8) repl_q[k] <= cfg_data_i[8*(k%8) +: 8];
          end
        end
        default: begin
        end
      endcase
    end
  end

  `SSR_ASSERT(a_fill_below_len, (fill_q != '0) |-> (fill_q < plen), "window reached pattern length")
  `SSR_ASSERT(a_push_stall, push_o |-> !in_stall_o, "request built while stalled")

endmodule

>>> hw/rtl/ssr_back.sv
// Back part: expands queued requests into result bytes behind an output register.
// Depends on ssr_pkg and stream_substring_replace_macros.svh.
`timescale 1ns / 1ps
`include "stream_substring_replace_macros.svh"

module ssr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  ssr_pkg::ssr_cmd_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ssr_pkg::ssr_out_t out_data_o
);

  ssr_pkg::ssr_cmd_t         cur_q;
  logic                      cur_valid_q;
  logic [ssr_pkg::POS_W-1:0] pos_q;
  logic [ssr_pkg::LEN_W-1:0] pos_inc;
  logic                      out_valid_q;
  ssr_pkg::ssr_out_t         out_q;
  logic load_out, step, done;

  assign load_out = !out_valid_q || !out_stall_i;
  assign step     = cur_valid_q && load_out;
  assign pos_inc  = ssr_pkg::LEN_W'(pos_q) + ssr_pkg::LEN_W'(1);
  assign done     = (pos_inc >= cur_q.len);
  assign pop_o    = avail_i && (!cur_valid_q || (step && done));

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        pos_q       <= '0;
      end else if (step) begin
        if (done) begin
          cur_valid_q <= 1'b0;
        end else begin
          pos_q <= pos_q + ssr_pkg::POS_W'(1);
        end
      end
      if (load_out) begin
        out_valid_q <= cur_valid_q;
      end
    end
  end

  // a bare end marker carries a zero byte
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (step) begin
      out_q.out_byte       <= (cur_q.len != '0) ? cur_q.body[pos_q] : 8'h00;
      out_q.out_byte_valid <= (cur_q.len != '0);
      out_q.out_last       <= cur_q.last && done;
      out_q.replace_count  <= cur_q.count;
    end
  end

  `SSR_ASSERT(a_empty_is_last, (cur_valid_q && (cur_q.len == '0)) |-> cur_q.last,
              "empty request not at end of string")
  `SSR_ASSERT(a_marker_last, (out_valid_q && !out_q.out_byte_valid) |-> out_q.out_last,
              "bare marker without last")

endmodule

>>> hw/rtl/stream_substring_replace.sv
// Top level of the streaming substring replacement block.
// Depends on ssr_pkg, ssr_front, ssr_fifo and ssr_back.
//
//   channel | direction | handshake          | payload
//   in      | input     | valid_i / stall_o  | ssr_pkg::ssr_in_t
//   out     | output    | valid_o / stall_i  | ssr_pkg::ssr_out_t
//   cfg     | input     | valid_i / ready_o  | index, 64-bit data
//
// One byte is accepted per cycle while the request queue has room.
// The back part emits one result per cycle while out_stall_i is low.
// cur_q takes a new request when empty or as its last result moves into out_q.
// Reset empties the window, queue and output register; configuration resets to zero.
// An output stall backs up into the queue, and in_stall_o rises only once the queue is full.
`timescale 1ns / 1ps

module stream_substring_replace #(
  parameter int MAX_PATTERN     = ssr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = ssr_pkg::MAX_REPLACEMENT_DEF,
  parameter int COUNT_WIDTH     = ssr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ssr_pkg::ssr_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ssr_pkg::ssr_out_t               out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  ssr_pkg::ssr_cmd_t push_cmd, head_cmd;
  logic push, full, pop, avail;

  ssr_front #(
    .MAX_PATTERN    (MAX_PATTERN),
    .MAX_REPLACEMENT(MAX_REPLACEMENT),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  ssr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .avail_o(avail),
    .data_o (head_cmd)
  );

  ssr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (avail),
    .head_i     (head_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
